[rtl/prk4_pkg.sv]
// ----------------------------------------------------------------------------
// prk4_pkg: shared types and constants of the particle rk4 integrator
// Q16.16 formats, register indexes, reset values and the saturate function.
// ----------------------------------------------------------------------------
package prk4_pkg;

  // signed Q16.16 value, one lane of a particle state
  typedef logic signed [31:0] q16_t;
  // velocity minus wind, exact
  typedef logic signed [32:0] diff_t;
  // drag coefficient times velocity difference
  typedef logic signed [57:0] prod_t;
  // rate times step length
  typedef logic signed [48:0] step_prod_t;
  // weighted rate sum k1 + 2 k2 + 2 k3 + k4
  typedef logic signed [34:0] ksum_t;
  // rate sum times step length
  typedef logic signed [51:0] fin_prod_t;
  // headroom for adds ahead of saturation
  typedef logic signed [41:0] wide_t;
  // weighted sum increment after the divide by six
  typedef logic signed [34:0] inc_t;
  typedef logic [15:0] dt_t;
  typedef logic [23:0] drag_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_TIME_STEP      = 3'd0,
    REG_DRAG_COEFF     = 3'd1,
    REG_WIND_X         = 3'd2,
    REG_WIND_Y         = 3'd3,
    REG_WIND_Z         = 3'd4,
    REG_GRAVITY_ENABLE = 3'd5
  } cfg_reg_t;

  localparam dt_t   TIME_STEP_RST = 16'd1092;
  localparam drag_t DRAG_RST      = 24'd0;
  localparam q16_t  WIND_RST      = 32'sd0;
  localparam logic  GRAVITY_RST   = 1'b1;

  // -9.81 in Q16.16, rounded to nearest
  localparam q16_t GRAVITY_Q16 = -32'sd642908;

  // final divide by 6 * 2^16: bias of half the divisor plus 3 * 2^48, which
  // keeps the quotient positive (it adds exactly 2^31 after the divide)
  localparam fin_prod_t FIN_BIAS   = 52'sd844424930328576;
  localparam inc_t      DIV_OFFSET = 35'sd2147483648;
  // divide by three: 2^18 = 3 * 87381 + 1, small part by reciprocal
  localparam logic [16:0] DIV3_HI    = 17'd87381;
  localparam logic [18:0] DIV3_RECIP = 19'd349526;

  // cycles from item accept to the result strobe being sampled
  localparam int unsigned LATENCY = 25;

  localparam wide_t Q16_MAX = 42'sd2147483647;
  localparam wide_t Q16_MIN = -42'sd2147483648;

  // clamp to the signed 32 bit range
  function automatic q16_t sat_q16(input wide_t x);
    q16_t r;
    if (x > Q16_MAX) begin
      r = 32'sh7fffffff;
    end else if (x < Q16_MIN) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

[rtl/particle_rk4_drag_step_top.sv]
// ----------------------------------------------------------------------------
// particle_rk4_drag_step_top: rk4 particle step with linear drag and gravity
// Fully pipelined Q16.16 integrator, four rate stages and a divide-by-six tail.
// ----------------------------------------------------------------------------
// One particle state enters per clock: busy is always low, so every cycle with
// start high is an item. Its result strobes on out_valid for one cycle; its
// delay after the accepting edge is set by the four rate-evaluation stages
// (five register stages each, four for the last) and the six-stage final sum
// and divide. The receiver cannot stall the block and nothing is held back.
// Configuration writes are always ready and take effect at once; write them
// while no item is in flight.
module particle_rk4_drag_step_top (
  input  logic        clk,
  input  logic        rst_n,
  // item input
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_pos_x,
  input  logic [31:0] in_pos_y,
  input  logic [31:0] in_pos_z,
  input  logic [31:0] in_vel_x,
  input  logic [31:0] in_vel_y,
  input  logic [31:0] in_vel_z,
  // result output
  output logic        out_valid,
  output logic [31:0] out_next_pos_x,
  output logic [31:0] out_next_pos_y,
  output logic [31:0] out_next_pos_z,
  output logic [31:0] out_next_vel_x,
  output logic [31:0] out_next_vel_y,
  output logic [31:0] out_next_vel_z,
  // configuration write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  // configuration registers
  prk4_pkg::dt_t   dt_r;
  prk4_pkg::drag_t drag_r;
  prk4_pkg::q16_t  wind_r [3];
  logic            grav_r;

  logic in_accept;

  // stage inputs: index 0 from the ports, n + 1 from stage n
  logic             stg_vld [4];
  prk4_pkg::q16_t   stg_s0  [4][6];
  prk4_pkg::q16_t   stg_v   [4][3];
  prk4_pkg::ksum_t  stg_sum [4][6];

  // last stage output into the final sum
  logic             fin_vld;
  prk4_pkg::q16_t   fin_s0  [6];
  prk4_pkg::ksum_t  fin_sum [6];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign in_accept = start && !busy;

  // configuration write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dt_r      <= prk4_pkg::TIME_STEP_RST;
      drag_r    <= prk4_pkg::DRAG_RST;
      wind_r[0] <= prk4_pkg::WIND_RST;
      wind_r[1] <= prk4_pkg::WIND_RST;
      wind_r[2] <= prk4_pkg::WIND_RST;
      grav_r    <= prk4_pkg::GRAVITY_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (prk4_pkg::cfg_reg_t'(cfg_index))
        prk4_pkg::REG_TIME_STEP:      dt_r      <= cfg_data[15:0];
        prk4_pkg::REG_DRAG_COEFF:     drag_r    <= cfg_data[23:0];
        prk4_pkg::REG_WIND_X:         wind_r[0] <= cfg_data;
        prk4_pkg::REG_WIND_Y:         wind_r[1] <= cfg_data;
        prk4_pkg::REG_WIND_Z:         wind_r[2] <= cfg_data;
        prk4_pkg::REG_GRAVITY_ENABLE: grav_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // first stage takes the item straight from the ports
  assign stg_vld[0]   = in_accept;
  assign stg_s0[0][0] = in_pos_x;
  assign stg_s0[0][1] = in_pos_y;
  assign stg_s0[0][2] = in_pos_z;
  assign stg_s0[0][3] = in_vel_x;
  assign stg_s0[0][4] = in_vel_y;
  assign stg_s0[0][5] = in_vel_z;
  assign stg_v[0][0]  = in_vel_x;
  assign stg_v[0][1]  = in_vel_y;
  assign stg_v[0][2]  = in_vel_z;
  for (genvar j = 0; j < 6; j++) begin : g_sum_init
    assign stg_sum[0][j] = '0;
  end

  // four rate stages; only the velocity lanes of an intermediate state are
  // needed, since the position rate is the stage velocity itself
  for (genvar n = 0; n < 4; n++) begin : g_stage
    localparam int unsigned SHIFT = (n == 2) ? 16 : 17;
    localparam int unsigned WSH   = (n == 1 || n == 2) ? 1 : 0;

    logic                  vld1_r, vld2_r, vld3_r, vld4_r;
    prk4_pkg::q16_t        s0_1_r [6];
    prk4_pkg::q16_t        s0_2_r [6];
    prk4_pkg::q16_t        s0_3_r [6];
    prk4_pkg::q16_t        s0_4_r [6];
    prk4_pkg::ksum_t       sum1_r [6];
    prk4_pkg::ksum_t       sum2_r [6];
    prk4_pkg::ksum_t       sum3_r [6];
    prk4_pkg::ksum_t       sum4_r [6];
    prk4_pkg::q16_t        v1_r   [3];
    prk4_pkg::q16_t        v2_r   [3];
    prk4_pkg::diff_t       diff_nxt [3];
    prk4_pkg::diff_t       diff_r   [3];
    prk4_pkg::prod_t       prod_nxt [3];
    prk4_pkg::prod_t       prod_r   [3];
    prk4_pkg::q16_t        k_nxt    [6];
    prk4_pkg::q16_t        k_r      [6];
    prk4_pkg::ksum_t       sum4_nxt [6];

    // velocity minus wind
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        diff_nxt[i] = prk4_pkg::diff_t'(stg_v[n][i]) - prk4_pkg::diff_t'(wind_r[i]);
      end
    end

    // drag product
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        prod_nxt[i] = prk4_pkg::prod_t'($signed({1'b0, drag_r}))
                    * prk4_pkg::prod_t'(diff_r[i]);
      end
    end

    // rates: position rate is velocity, velocity rate is gravity minus drag
    always_comb begin
      prk4_pkg::prod_t pr;
      prk4_pkg::wide_t gv;
      prk4_pkg::wide_t dv;
      for (int i = 0; i < 3; i++) begin
        pr = prod_r[i] + 58'sd32768;
        dv = $signed(pr[57:16]);
        gv = (i == 1 && grav_r) ? prk4_pkg::wide_t'(prk4_pkg::GRAVITY_Q16) : '0;
        k_nxt[i]     = v2_r[i];
        k_nxt[3 + i] = prk4_pkg::sat_q16(gv - dv);
      end
    end

    // weighted rate sum
    always_comb begin
      for (int j = 0; j < 6; j++) begin
        sum4_nxt[j] = sum3_r[j] + (prk4_pkg::ksum_t'(k_r[j]) <<< WSH);
      end
    end

    // valid bits
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld1_r <= 1'b0;
        vld2_r <= 1'b0;
        vld3_r <= 1'b0;
        vld4_r <= 1'b0;
      end else begin
        vld1_r <= stg_vld[n];
        vld2_r <= vld1_r;
        vld3_r <= vld2_r;
        vld4_r <= vld3_r;
      end
    end

    // payload
    always_ff @(posedge clk) begin
      s0_1_r   <= stg_s0[n];
      s0_2_r   <= s0_1_r;
      s0_3_r   <= s0_2_r;
      s0_4_r   <= s0_3_r;
      sum1_r   <= stg_sum[n];
      sum2_r   <= sum1_r;
      sum3_r   <= sum2_r;
      sum4_r   <= sum4_nxt;
      v1_r     <= stg_v[n];
      v2_r     <= v1_r;
      diff_r   <= diff_nxt;
      prod_r   <= prod_nxt;
      k_r      <= k_nxt;
    end

    if (n < 3) begin : g_adv
      logic                  vld5_r;
      prk4_pkg::q16_t        s0_5_r [6];
      prk4_pkg::ksum_t       sum5_r [6];
      prk4_pkg::step_prod_t  kdt_nxt  [3];
      prk4_pkg::step_prod_t  kdt_r    [3];
      prk4_pkg::q16_t        vnew_nxt [3];
      prk4_pkg::q16_t        vnew_r   [3];

      // velocity rate times step length
      always_comb begin
        for (int i = 0; i < 3; i++) begin
          kdt_nxt[i] = prk4_pkg::step_prod_t'($signed({1'b0, dt_r}))
                     * prk4_pkg::step_prod_t'(k_r[3 + i]);
        end
      end

      // half or full step velocity from the start state
      always_comb begin
        prk4_pkg::step_prod_t mr;
        prk4_pkg::wide_t      inc;
        for (int i = 0; i < 3; i++) begin
          mr  = kdt_r[i] + (prk4_pkg::step_prod_t'(1) <<< (SHIFT - 1));
          inc = prk4_pkg::wide_t'(mr >>> SHIFT);
          vnew_nxt[i] = prk4_pkg::sat_q16(prk4_pkg::wide_t'(s0_4_r[3 + i]) + inc);
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld5_r <= 1'b0;
        end else begin
          vld5_r <= vld4_r;
        end
      end

      always_ff @(posedge clk) begin
        s0_5_r <= s0_4_r;
        sum5_r <= sum4_r;
        kdt_r  <= kdt_nxt;
        vnew_r <= vnew_nxt;
      end

      assign stg_vld[n + 1] = vld5_r;
      assign stg_s0[n + 1]  = s0_5_r;
      assign stg_sum[n + 1] = sum5_r;
      assign stg_v[n + 1]   = vnew_r;
    end else begin : g_last
      assign fin_vld = vld4_r;
      assign fin_s0  = s0_4_r;
      assign fin_sum = sum4_r;
    end
  end

  // final update: s0 + floor((S * dt + 3 * 2^16) / (6 * 2^16))
  logic                 fv1_r, fv2_r, fv3_r, fv4_r, fv5_r, out_valid_r;
  prk4_pkg::q16_t       fs0_1_r [6];
  prk4_pkg::q16_t       fs0_2_r [6];
  prk4_pkg::q16_t       fs0_3_r [6];
  prk4_pkg::q16_t       fs0_4_r [6];
  prk4_pkg::q16_t       fs0_5_r [6];
  prk4_pkg::fin_prod_t  x_nxt   [6];
  prk4_pkg::fin_prod_t  x_r     [6];
  logic [33:0]          u_nxt   [6];
  logic [33:0]          u_r     [6];
  logic [32:0]          p_nxt   [6];
  logic [32:0]          p_r     [6];
  logic [32:0]          p4_r    [6];
  logic [18:0]          c_nxt   [6];
  logic [18:0]          c_r     [6];
  logic [18:0]          c4_r    [6];
  logic [37:0]          cm_nxt  [6];
  logic [37:0]          cm_r    [6];
  logic [17:0]          q3      [6];
  prk4_pkg::inc_t       w_nxt   [6];
  prk4_pkg::inc_t       w_r     [6];
  prk4_pkg::q16_t       out_nxt [6];
  prk4_pkg::q16_t       out_r   [6];

  always_comb begin
    prk4_pkg::fin_prod_t xb;
    for (int j = 0; j < 6; j++) begin
      // rate sum times step length
      x_nxt[j] = prk4_pkg::fin_prod_t'(fin_sum[j])
               * prk4_pkg::fin_prod_t'($signed({1'b0, dt_r}));
      // biased and floored by 2^17, always positive
      xb       = x_r[j] + prk4_pkg::FIN_BIAS;
      u_nxt[j] = xb[50:17];
      // divide by three: high part by constant, low part by reciprocal
      p_nxt[j]  = 33'(u_r[j][33:18]) * 33'(prk4_pkg::DIV3_HI);
      c_nxt[j]  = 19'(u_r[j][33:18]) + 19'(u_r[j][17:0]);
      cm_nxt[j] = 38'(c_r[j]) * 38'(prk4_pkg::DIV3_RECIP);
      q3[j]     = cm_r[j][37:20];
      w_nxt[j]  = $signed({2'b00, p4_r[j]}) + $signed(35'(q3[j])) - prk4_pkg::DIV_OFFSET;
      out_nxt[j] = prk4_pkg::sat_q16(prk4_pkg::wide_t'(fs0_5_r[j])
                                     + prk4_pkg::wide_t'(w_r[j]));
    end
  end

  // final valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv1_r       <= 1'b0;
      fv2_r       <= 1'b0;
      fv3_r       <= 1'b0;
      fv4_r       <= 1'b0;
      fv5_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      fv1_r       <= fin_vld;
      fv2_r       <= fv1_r;
      fv3_r       <= fv2_r;
      fv4_r       <= fv3_r;
      fv5_r       <= fv4_r;
      out_valid_r <= fv5_r;
    end
  end

  // final payload
  always_ff @(posedge clk) begin
    fs0_1_r <= fin_s0;
    fs0_2_r <= fs0_1_r;
    fs0_3_r <= fs0_2_r;
    fs0_4_r <= fs0_3_r;
    fs0_5_r <= fs0_4_r;
    x_r     <= x_nxt;
    u_r     <= u_nxt;
    p_r     <= p_nxt;
    c_r     <= c_nxt;
    p4_r    <= p_r;
    c4_r    <= c_r;
    cm_r    <= cm_nxt;
    w_r     <= w_nxt;
    out_r   <= out_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_next_pos_x = out_r[0];
  assign out_next_pos_y = out_r[1];
  assign out_next_pos_z = out_r[2];
  assign out_next_vel_x = out_r[3];
  assign out_next_vel_y = out_r[4];
  assign out_next_vel_z = out_r[5];

  // a result only ever follows an accepted item by the fixed latency
  a_out_follows_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_accept, prk4_pkg::LATENCY))
    else $error("result strobe without an item accepted at the pipeline latency");

  // reciprocal divide by three leaves a remainder of 0 to 2
  for (genvar j = 0; j < 6; j++) begin : g_div_chk
    a_div3_rem: assert property (@(posedge clk) disable iff (!rst_n)
      fv4_r |-> ((21'(c4_r[j]) - 21'd3 * 21'(q3[j])) <= 21'd2))
      else $error("divide by three remainder out of range");
  end

endmodule

[bench/rk4_check_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rk4_check_pkg: next-state predictor and in-order checker for the rk4 step
// Keeps its own copy of the register file, predicts the next particle state
// for every accepted item and checks each strobed result against the oldest.
// ----------------------------------------------------------------------------
package rk4_check_pkg;
  import prk4_pkg::*;

  // one particle state, position then velocity
  typedef struct packed {
    q16_t pos_x;
    q16_t pos_y;
    q16_t pos_z;
    q16_t vel_x;
    q16_t vel_y;
    q16_t vel_z;
  } particle_t;

  // wide working lanes, same order as particle_t
  typedef longint lanes_t [6];

  localparam longint LANE_MAX     = 64'sh7fffffff;
  localparam longint LANE_MIN     = -64'sh80000000;
  // final divide by six in Q16.16, with half the divisor for rounding
  localparam longint SIX_DIVISOR  = 64'sd393216;
  localparam longint SIX_HALF     = 64'sd196608;
  localparam int     HALF_SHIFT   = 17;
  localparam int     FULL_SHIFT   = 16;

  class rk4_step_checker;
    longint      step_len;
    longint      drag;
    longint      wind [3];
    bit          gravity_on;
    particle_t   next_states [$];
    int unsigned failures;

    function new();
      step_len   = TIME_STEP_RST;
      drag       = DRAG_RST;
      wind[0]    = WIND_RST;
      wind[1]    = WIND_RST;
      wind[2]    = WIND_RST;
      gravity_on = GRAVITY_RST;
      failures   = 0;
    endfunction

    // register write, narrow registers drop their upper bits
    function void apply_register(logic [2:0] index, logic [31:0] data);
      case (index)
        REG_TIME_STEP: begin
          step_len = longint'(data[15:0]);
        end
        REG_DRAG_COEFF: begin
          drag = longint'(data[23:0]);
        end
        REG_WIND_X: begin
          wind[0] = longint'(signed'(data));
        end
        REG_WIND_Y: begin
          wind[1] = longint'(signed'(data));
        end
        REG_WIND_Z: begin
          wind[2] = longint'(signed'(data));
        end
        REG_GRAVITY_ENABLE: begin
          gravity_on = data[0];
        end
        default: begin
        end
      endcase
    endfunction

    static function longint clamp32(longint x);
      if (x > LANE_MAX) return LANE_MAX;
      if (x < LANE_MIN) return LANE_MIN;
      return x;
    endfunction

    // round half up, then arithmetic shift
    static function longint round_shift(longint x, int n);
      return (x + (longint'(1) <<< (n - 1))) >>> n;
    endfunction

    // derivative of a stage state: velocity, gravity minus drag toward wind
    function void rates(input lanes_t s, output lanes_t k);
      longint drag_term;
      longint g;
      int     i;
      for (i = 0; i < 3; i++) begin
        drag_term = round_shift(drag * (s[3 + i] - wind[i]), FULL_SHIFT);
        g = (i == 1 && gravity_on) ? longint'(GRAVITY_Q16) : 64'sd0;
        k[i]     = s[3 + i];
        k[3 + i] = clamp32(g - drag_term);
      end
    endfunction

    // stage state from the start state and one derivative
    function void advance(input lanes_t s0, input lanes_t k, input int shift,
                          output lanes_t s);
      int i;
      for (i = 0; i < 6; i++) begin
        s[i] = clamp32(s0[i] + round_shift(k[i] * step_len, shift));
      end
    endfunction

    // predict the next state of an accepted item
    function void note_particle(particle_t p);
      lanes_t    s0;
      lanes_t    s;
      lanes_t    k1;
      lanes_t    k2;
      lanes_t    k3;
      lanes_t    k4;
      longint    acc;
      longint    inc;
      particle_t r;
      int        i;
      s0[0] = p.pos_x;
      s0[1] = p.pos_y;
      s0[2] = p.pos_z;
      s0[3] = p.vel_x;
      s0[4] = p.vel_y;
      s0[5] = p.vel_z;
      rates(s0, k1);
      advance(s0, k1, HALF_SHIFT, s);
      rates(s, k2);
      advance(s0, k2, HALF_SHIFT, s);
      rates(s, k3);
      advance(s0, k3, FULL_SHIFT, s);
      rates(s, k4);
      // weighted sum, floor divide by six
      for (i = 0; i < 6; i++) begin
        acc = (k1[i] + 2 * k2[i] + 2 * k3[i] + k4[i]) * step_len + SIX_HALF;
        inc = acc / SIX_DIVISOR;
        if ((acc % SIX_DIVISOR) != 0 && acc < 0) inc = inc - 1;
        s[i] = clamp32(s0[i] + inc);
      end
      r.pos_x = s[0][31:0];
      r.pos_y = s[1][31:0];
      r.pos_z = s[2][31:0];
      r.vel_x = s[3][31:0];
      r.vel_y = s[4][31:0];
      r.vel_z = s[5][31:0];
      next_states.push_back(r);
    endfunction

    function void compare_lane(string name, q16_t want, q16_t got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        failures++;
      end
    endfunction

    // compare a strobed result with the oldest prediction
    function void check_particle(particle_t got);
      particle_t want;
      if (next_states.size() == 0) begin
        $error("result with no item in flight");
        failures++;
        return;
      end
      want = next_states.pop_front();
      compare_lane("next_pos_x", want.pos_x, got.pos_x);
      compare_lane("next_pos_y", want.pos_y, got.pos_y);
      compare_lane("next_pos_z", want.pos_z, got.pos_z);
      compare_lane("next_vel_x", want.vel_x, got.vel_x);
      compare_lane("next_vel_y", want.vel_y, got.vel_y);
      compare_lane("next_vel_z", want.vel_z, got.vel_z);
    endfunction

    function int pending();
      return next_states.size();
    endfunction
  endclass

endpackage

[bench/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: particle rk4 drag step, streaming check
// Drives particle states through the integrator under several register
// settings and sender idle profiles, predicts every next state and checks
// all results in order; a watchdog ends a stuck run.
// ----------------------------------------------------------------------------
module testbench;
  import prk4_pkg::*;
  import rk4_check_pkg::*;

  localparam int unsigned QUIET_LIMIT     = 4000;
  localparam int unsigned ITEMS_PER_PHASE = 150;
  localparam int unsigned PHASES          = 6;
  // indexes past the register list, writes there are dropped
  localparam logic [2:0]  REG_SPARE_LO    = 3'd6;
  localparam logic [2:0]  REG_SPARE_HI    = 3'd7;
  localparam q16_t        Q_MAX           = 32'sh7fffffff;
  localparam q16_t        Q_MIN           = 32'sh80000000;
  localparam q16_t        Q_ONE           = 32'sh00010000;
  localparam q16_t        Q_TEN           = 32'sh000a0000;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        start     = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data  = '0;
  particle_t   in_state  = '0;
  logic        busy;
  logic        out_valid;
  logic        cfg_ready;
  logic [31:0] out_next_pos_x;
  logic [31:0] out_next_pos_y;
  logic [31:0] out_next_pos_z;
  logic [31:0] out_next_vel_x;
  logic [31:0] out_next_vel_y;
  logic [31:0] out_next_vel_z;

  int unsigned sender_idle_pct = 0;
  int unsigned quiet_cycles    = 0;

  rk4_step_checker chk = new();

  always #5 clk = ~clk;

  particle_rk4_drag_step_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_pos_x       (in_state.pos_x),
    .in_pos_y       (in_state.pos_y),
    .in_pos_z       (in_state.pos_z),
    .in_vel_x       (in_state.vel_x),
    .in_vel_y       (in_state.vel_y),
    .in_vel_z       (in_state.vel_z),
    .out_valid      (out_valid),
    .out_next_pos_x (out_next_pos_x),
    .out_next_pos_y (out_next_pos_y),
    .out_next_pos_z (out_next_pos_z),
    .out_next_vel_x (out_next_vel_x),
    .out_next_vel_y (out_next_vel_y),
    .out_next_vel_z (out_next_vel_z),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // monitor: register writes, accepted items, strobed results, watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) chk.apply_register(cfg_index, cfg_data);
      if (start && !busy) chk.note_particle(in_state);
      if (out_valid) begin
        chk.check_particle(particle_t'{out_next_pos_x, out_next_pos_y, out_next_pos_z,
                                       out_next_vel_x, out_next_vel_y, out_next_vel_z});
      end
    end
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // modest signed value, about +-32.0
  function automatic q16_t small_lane();
    return q16_t'(int'($urandom_range(4194304)) - 2097152);
  endfunction

  // mix of extremes, full-range words and modest values
  function automatic q16_t random_lane();
    q16_t v;
    case ($urandom_range(7))
      0: begin
        case ($urandom_range(4))
          0: v = Q_MAX;
          1: v = Q_MIN;
          2: v = '0;
          3: v = 32'sd1;
          default: v = -32'sd1;
        endcase
      end
      1, 2, 3: v = $urandom();
      default: v = small_lane();
    endcase
    return v;
  endfunction

  function automatic particle_t random_particle();
    return particle_t'{random_lane(), random_lane(), random_lane(),
                       random_lane(), random_lane(), random_lane()};
  endfunction

  // one register write, valid left high for the next one
  task automatic write_register(input logic [2:0] index, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  // full register set, junk in the unused upper bits
  task automatic load_registers(input logic [15:0] step_len, input logic [23:0] drag,
                                input q16_t wind_x, input q16_t wind_y, input q16_t wind_z,
                                input logic gravity);
    write_register(REG_TIME_STEP, {16'($urandom()), step_len});
    write_register(REG_DRAG_COEFF, {8'($urandom()), drag});
    write_register(REG_WIND_X, wind_x);
    write_register(REG_WIND_Y, wind_y);
    write_register(REG_WIND_Z, wind_z);
    write_register(REG_GRAVITY_ENABLE, {31'($urandom()), gravity});
    write_register(REG_SPARE_LO, $urandom());
    write_register(REG_SPARE_HI, $urandom());
    cfg_valid <= 1'b0;
  endtask

  // offer one item, idling at random first; start stays high on return
  task automatic send_particle(input particle_t p);
    while ($urandom_range(99) < sender_idle_pct) begin
      start    <= 1'b0;
      in_state <= random_particle();
      @(negedge clk);
    end
    start    <= 1'b1;
    in_state <= p;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // hold off until every predicted result has come back
  task automatic wait_for_results();
    start <= 1'b0;
    while (chk.pending() != 0) @(negedge clk);
  endtask

  initial begin
    int unsigned phase;
    int unsigned n;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    sender_idle_pct = 28;

    // extremes under the reset register values
    send_particle(particle_t'{default: '0});
    send_particle(particle_t'{default: Q_MAX});
    send_particle(particle_t'{default: Q_MIN});
    send_particle(particle_t'{'0, '0, '0, Q_MAX, Q_MAX, Q_MAX});
    send_particle(particle_t'{'0, '0, '0, Q_MIN, Q_MIN, Q_MIN});
    send_particle(particle_t'{Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN});
    send_particle(particle_t'{Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX});
    send_particle(particle_t'{default: 32'sh55555555});
    send_particle(particle_t'{default: 32'shaaaaaaaa});
    send_particle(particle_t'{Q_ONE, Q_ONE, Q_ONE, Q_TEN, Q_TEN, Q_TEN});
    wait_for_results();

    // longest step, strongest drag, wind x and y at their limits
    load_registers(16'hffff, 24'hffffff, Q_MAX, Q_MIN, '0, 1'b1);
    send_particle(particle_t'{default: '0});
    send_particle(particle_t'{default: Q_MAX});
    send_particle(particle_t'{default: Q_MIN});
    send_particle(particle_t'{Q_ONE, Q_ONE, Q_ONE, Q_MIN, Q_MAX, Q_MIN});
    wait_for_results();

    // zero step: state passes through unchanged
    load_registers('0, 24'($urandom()), $urandom(), $urandom(), $urandom(), 1'b1);
    send_particle(random_particle());
    send_particle(random_particle());
    send_particle(random_particle());
    send_particle(particle_t'{default: Q_MIN});
    wait_for_results();

    // random items, one register setting per phase
    for (phase = 0; phase < PHASES; phase++) begin
      sender_idle_pct = (phase < 2) ? 28 : (phase < 4) ? 70 : 0;
      case (phase)
        0: load_registers(16'hffff, 24'hffffff, Q_MAX, Q_MIN, Q_MAX, 1'b1);
        1: load_registers(16'($urandom_range(4096)), 24'($urandom_range(262143)),
                          small_lane(), small_lane(), small_lane(), 1'($urandom()));
        2: load_registers(16'($urandom()), 24'($urandom()), $urandom(), $urandom(),
                          $urandom(), 1'($urandom()));
        3: load_registers(16'hffff, 24'($urandom_range(1048575)), $urandom(), $urandom(),
                          $urandom(), 1'b0);
        4: load_registers(16'd1, '0, Q_MIN, Q_MIN, Q_MIN, 1'b0);
        default: load_registers(16'($urandom_range(8192)), 24'($urandom_range(1048575)),
                                small_lane(), small_lane(), small_lane(), 1'b1);
      endcase
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        // mid-phase pause until the pipeline is empty
        if (n == ITEMS_PER_PHASE / 2) wait_for_results();
        send_particle(random_particle());
      end
      wait_for_results();
    end

    // tail: catch any stray result
    repeat (LATENCY + 5) @(negedge clk);
    if (chk.failures == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/prk4_pkg.sv
rtl/particle_rk4_drag_step_top.sv
bench/rk4_check_pkg.sv
bench/testbench.sv
